/* hw/rtl/ccmac_pkg.sv */
// Shared types, constants and binary32 arithmetic helpers for the complex MAC block.
`timescale 1ns / 1ps
package ccmac_pkg;

    // Sizes of the accumulator store and of the frame counters.
    localparam int MAX_CHANNELS = 128;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int MAX_SIDE     = 256;
    localparam int SIDE_W       = $clog2(MAX_SIDE);
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 9;
    localparam int MANT_W       = 51;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FRAME_SIDE   = 2'd0,
        REG_CHANNELS_IN  = 2'd1,
        REG_CHANNELS_OUT = 2'd2
    } cfg_index_t;

    // Bookkeeping that travels with each request down the pipeline.
    typedef struct packed {
        logic [CH_W-1:0] oc;
        logic            first;
        logic            last_in;
        logic            last_out;
        logic            last_frame;
    } item_ctrl_t;

    // One complex operand pair: feature (a, b) and filter (c, d).
    typedef struct packed {
        logic [31:0] filter_imag;
        logic [31:0] filter_real;
        logic [31:0] fmap_imag;
        logic [31:0] fmap_real;
    } item_data_t;

    // Unrounded result between the front half and the rounding half of an operation.
    typedef struct packed {
        logic                    spec;
        logic [31:0]             sval;
        logic                    sgn;
        logic signed [11:0]      q;
        logic [MANT_W-1:0]       m;
    } fp_mid_t;

    function automatic logic fp_is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic fp_is_inf(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    endfunction

    function automatic logic fp_is_zero(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    function automatic logic [23:0] fp_mant(input logic [31:0] x);
        return (x[30:23] == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
    endfunction

    function automatic logic signed [11:0] fp_qexp(input logic [31:0] x);
        return (x[30:23] == 8'd0) ? -12'sd149 : ($signed({4'b0, x[30:23]}) - 12'sd150);
    endfunction

    // Round sign * m * 2^q to binary32, nearest even; the lsb of m may be a sticky bit.
    function automatic logic [31:0] fp_round_pack(input logic s, input logic signed [11:0] q,
                                                  input logic [MANT_W-1:0] m);
        logic [5:0]         p;
        logic signed [12:0] sh;
        logic signed [12:0] smin;
        logic signed [12:0] e0;
        logic signed [12:0] bexp;
        logic [MANT_W:0]    k;
        logic [MANT_W:0]    rem;
        logic [MANT_W:0]    half;
        logic [MANT_W:0]    mask;
        logic [5:0]         sa;
        logic               up;
        p = 6'd0;
        for (int i = 0; i < MANT_W; i++) begin
            if (m[i]) begin
                p = 6'(i);
            end
        end
        sh = $signed({7'b0, p}) - 13'sd23;
        smin = -13'sd149 - 13'(q);
        if (smin > sh) begin
            sh = smin;
        end
        up = 1'b0;
        sa = 6'd0;
        if (sh <= 0) begin
            k = {1'b0, m} << 6'(-sh);
        end else if (sh > 13'sd51) begin
            k = '0;
        end else begin
            sa   = 6'(sh);
            half = (MANT_W+1)'(1) << (sa - 6'd1);
            mask = ((MANT_W+1)'(1) << sa) - (MANT_W+1)'(1);
            rem  = {1'b0, m} & mask;
            k    = {1'b0, m} >> sa;
            up   = (rem > half) || ((rem == half) && k[0]);
        end
        k = k + (MANT_W+1)'(up);
        e0 = 13'(q) + sh;
        if (k[24]) begin
            k  = k >> 1;
            e0 = e0 + 13'sd1;
        end
        bexp = e0 + 13'sd150;
        if (m == '0) begin
            return {s, 31'd0};
        end else if (k[23]) begin
            if (bexp >= 13'sd255) begin
                return {s, 8'hFF, 23'd0};
            end
            return {s, bexp[7:0], k[22:0]};
        end
        return {s, 8'd0, k[22:0]};
    endfunction

    function automatic logic [31:0] fp_finish(input fp_mid_t x);
        return x.spec ? x.sval : fp_round_pack(x.sgn, x.q, x.m);
    endfunction

    // Front half of a multiply: special values and the exact significand product.
    function automatic fp_mid_t fp_mul_front(input logic [31:0] a, input logic [31:0] b);
        fp_mid_t     r;
        logic        s;
        logic [47:0] prod;
        s      = a[31] ^ b[31];
        prod   = fp_mant(a) * fp_mant(b);
        r.spec = 1'b0;
        r.sval = 32'd0;
        r.sgn  = s;
        r.q    = fp_qexp(a) + fp_qexp(b);
        r.m    = MANT_W'(prod);
        if (fp_is_nan(a) || fp_is_nan(b)) begin
            r.spec = 1'b1;
            r.sval = QNAN;
        end else if ((fp_is_inf(a) && fp_is_zero(b)) || (fp_is_inf(b) && fp_is_zero(a))) begin
            r.spec = 1'b1;
            r.sval = QNAN;
        end else if (fp_is_inf(a) || fp_is_inf(b)) begin
            r.spec = 1'b1;
            r.sval = {s, 8'hFF, 23'd0};
        end
        return r;
    endfunction

    // Front half of an add: special values, alignment with sticky, and the exact sum.
    function automatic fp_mid_t fp_add_front(input logic [31:0] a, input logic [31:0] b);
        fp_mid_t            r;
        logic [23:0]        mx;
        logic [23:0]        my;
        logic [23:0]        lost;
        logic signed [11:0] qx;
        logic signed [11:0] qy;
        logic signed [11:0] d;
        logic signed [11:0] rs;
        logic               sx;
        logic               sy;
        logic [MANT_W-1:0]  xs;
        logic [MANT_W-1:0]  ys;
        if (fp_qexp(a) >= fp_qexp(b)) begin
            mx = fp_mant(a); qx = fp_qexp(a); sx = a[31];
            my = fp_mant(b); qy = fp_qexp(b); sy = b[31];
        end else begin
            mx = fp_mant(b); qx = fp_qexp(b); sx = b[31];
            my = fp_mant(a); qy = fp_qexp(a); sy = a[31];
        end
        d    = qx - qy;
        rs   = d - 12'sd26;
        lost = 24'd0;
        r.spec = 1'b0;
        r.sval = 32'd0;
        if (d <= 12'sd26) begin
            xs  = MANT_W'(mx) << 5'(d);
            ys  = MANT_W'(my);
            r.q = qy;
        end else begin
            xs  = MANT_W'(mx) << 26;
            r.q = qx - 12'sd26;
            if (rs < 12'sd24) begin
                lost = my & ((24'd1 << 5'(rs)) - 24'd1);
                ys   = MANT_W'(my >> 5'(rs)) | MANT_W'(|lost);
            end else begin
                ys = MANT_W'(my != 24'd0);
            end
        end
        if (sx == sy) begin
            r.sgn = sx;
            r.m   = xs + ys;
        end else if (xs > ys) begin
            r.sgn = sx;
            r.m   = xs - ys;
        end else if (ys > xs) begin
            r.sgn = sy;
            r.m   = ys - xs;
        end else begin
            // Exact cancellation of unlike signs gives +0.
            r.sgn  = 1'b0;
            r.m    = '0;
            r.spec = 1'b1;
            r.sval = 32'd0;
        end
        if (fp_is_nan(a) || fp_is_nan(b)) begin
            r.spec = 1'b1;
            r.sval = QNAN;
        end else if (fp_is_inf(a) && fp_is_inf(b)) begin
            r.spec = 1'b1;
            r.sval = (a[31] == b[31]) ? a : QNAN;
        end else if (fp_is_inf(a)) begin
            r.spec = 1'b1;
            r.sval = a;
        end else if (fp_is_inf(b)) begin
            r.spec = 1'b1;
            r.sval = b;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/complex_conj_mac_channel_accumulate.sv */
// Top level of the complex conjugate multiply-accumulate over input channels.
`timescale 1ns / 1ps
// Items arrive pixel by pixel, input channel by input channel, with the output
// channel varying fastest; each one adds feature times conjugate filter into the
// accumulator of its output channel, and items of the last input channel send
// the finished binary32 sum. While no result stalls, the block takes one request
// per cycle whenever at least two output channels, or a single input channel,
// are configured; with a single output channel and more than one input channel
// a request past the first input channel waits while the one just ahead sits in
// the first pipeline stage, because the accumulator read of an item must see the
// store write of the item just ahead (the two-stage accumulate adder closes that
// loop through a registered memory read port with a write bypass). A stalled
// result holds the whole pipeline. The accumulator store needs no clearing pass
// after reset: the first input channel of every pixel overwrites its entry.
module complex_conj_mac_channel_accumulate
    import ccmac_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // fmap_real[31:0], fmap_imag[63:32], filter_real[95:64], filter_imag[127:96]
    input  logic [127:0]          s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_real[31:0], out_imag[63:32], out_channel[70:64], zero pad[71]
    output logic [71:0]           m_tdata,
    // last_of_pixel[0]
    output logic [0:0]            m_tuser,
    output logic                  m_tlast
);

    logic        pipe_en;
    logic        accept;
    item_ctrl_t  item_ctrl;
    item_data_t  item_data;
    logic        prod_valid;
    item_ctrl_t  prod_ctrl;
    logic [31:0] prod_re, prod_im;

    assign item_data = s_tdata;

    ccmac_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .pipe_en   (pipe_en),
        .accept    (accept),
        .item_ctrl (item_ctrl)
    );

    ccmac_cmul u_cmul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe_en   (pipe_en),
        .in_valid  (accept),
        .in_data   (item_data),
        .in_ctrl   (item_ctrl),
        .out_valid (prod_valid),
        .out_ctrl  (prod_ctrl),
        .out_re    (prod_re),
        .out_im    (prod_im)
    );

    ccmac_acc u_acc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (prod_valid),
        .in_ctrl  (prod_ctrl),
        .in_re    (prod_re),
        .in_im    (prod_im),
        .pipe_en  (pipe_en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* hw/rtl/ccmac_ctrl.sv */
// Configuration registers, channel and pixel counters, and the input request gate.
`timescale 1ns / 1ps
module ccmac_ctrl
    import ccmac_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  pipe_en,
    output logic                  accept,
    output item_ctrl_t            item_ctrl
);

    logic [8:0]        frame_side_reg;
    logic [7:0]        channels_in_reg;
    logic [7:0]        channels_out_reg;
    logic [CH_W-1:0]   in_cnt_reg, in_cnt_next;
    logic [CH_W-1:0]   out_cnt_reg, out_cnt_next;
    logic [SIDE_W-1:0] col_cnt_reg, col_cnt_next;
    logic [SIDE_W-1:0] row_cnt_reg, row_cnt_next;
    logic              prev_valid_reg;
    logic [CH_W-1:0]   prev_oc_reg;
    logic [CH_W-1:0]   ci_m1;
    logic [CH_W-1:0]   co_m1;
    logic [SIDE_W-1:0] fs_m1;
    logic              last_in, last_out, last_col, last_row;
    logic              hazard;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_side_reg   <= 9'd75;
            channels_in_reg  <= 8'd32;
            channels_out_reg <= 8'd32;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FRAME_SIDE:   frame_side_reg   <= cfg_wdata;
                REG_CHANNELS_IN:  channels_in_reg  <= cfg_wdata[7:0];
                REG_CHANNELS_OUT: channels_out_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Last counter values: zero acts as one, oversized values saturate.
    always_comb begin
        if (channels_in_reg == 8'd0) begin
            ci_m1 = '0;
        end else if (channels_in_reg > 8'(MAX_CHANNELS)) begin
            ci_m1 = CH_W'(MAX_CHANNELS - 1);
        end else begin
            ci_m1 = CH_W'(channels_in_reg - 8'd1);
        end
        if (channels_out_reg == 8'd0) begin
            co_m1 = '0;
        end else if (channels_out_reg > 8'(MAX_CHANNELS)) begin
            co_m1 = CH_W'(MAX_CHANNELS - 1);
        end else begin
            co_m1 = CH_W'(channels_out_reg - 8'd1);
        end
        if (frame_side_reg == 9'd0) begin
            fs_m1 = '0;
        end else if (frame_side_reg > 9'(MAX_SIDE)) begin
            fs_m1 = SIDE_W'(MAX_SIDE - 1);
        end else begin
            fs_m1 = SIDE_W'(frame_side_reg - 9'd1);
        end
    end

    assign last_in  = in_cnt_reg >= ci_m1;
    assign last_out = out_cnt_reg >= co_m1;
    assign last_col = col_cnt_reg >= fs_m1;
    assign last_row = row_cnt_reg >= fs_m1;

    // A request that reads the entry written by the request just ahead waits while that request is in the first stage.
    assign hazard   = prev_valid_reg && (prev_oc_reg == out_cnt_reg) && (in_cnt_reg != '0);
    assign s_tready = pipe_en && !hazard;
    assign accept   = s_tvalid && s_tready;

    assign item_ctrl.oc         = out_cnt_reg;
    assign item_ctrl.first      = in_cnt_reg == '0;
    assign item_ctrl.last_in    = last_in;
    assign item_ctrl.last_out   = last_out;
    assign item_ctrl.last_frame = last_out && last_col && last_row;

    // Nested counter advance: output channel fastest, then input channel, column, row.
    always_comb begin
        in_cnt_next  = in_cnt_reg;
        out_cnt_next = out_cnt_reg;
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (!last_out) begin
            out_cnt_next = out_cnt_reg + CH_W'(1);
        end else begin
            out_cnt_next = '0;
            if (!last_in) begin
                in_cnt_next = in_cnt_reg + CH_W'(1);
            end else begin
                in_cnt_next = '0;
                if (!last_col) begin
                    col_cnt_next = col_cnt_reg + SIDE_W'(1);
                end else begin
                    col_cnt_next = '0;
                    row_cnt_next = last_row ? '0 : row_cnt_reg + SIDE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_cnt_reg     <= '0;
            out_cnt_reg    <= '0;
            col_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            prev_valid_reg <= 1'b0;
            prev_oc_reg    <= '0;
        end else begin
            if (accept) begin
                in_cnt_reg  <= in_cnt_next;
                out_cnt_reg <= out_cnt_next;
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
            // Mirror of the first pipeline stage.
            if (pipe_en) begin
                prev_valid_reg <= accept;
                prev_oc_reg    <= out_cnt_reg;
            end
        end
    end

endmodule

/* hw/rtl/ccmac_cmul.sv */
// Pipelined complex product of the feature value and the conjugate filter value.
`timescale 1ns / 1ps
module ccmac_cmul
    import ccmac_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        pipe_en,
    input  logic        in_valid,
    input  item_data_t  in_data,
    input  item_ctrl_t  in_ctrl,
    output logic        out_valid,
    output item_ctrl_t  out_ctrl,
    output logic [31:0] out_re,
    output logic [31:0] out_im
);

    logic [4:0]  vld_reg;
    item_ctrl_t  ctl_reg [5];
    item_data_t  d1_reg;
    fp_mid_t     ac_reg, bd_reg, bc_reg, ad_reg;
    logic [31:0] ac_f_reg, bd_f_reg, bc_f_reg, ad_f_reg;
    fp_mid_t     re_mid_reg, im_mid_reg;
    logic [31:0] re_reg, im_reg;

    // Valid and bookkeeping shift line.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ctl_reg[0] <= in_ctrl;
            for (int i = 1; i < 5; i++) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    // Operand capture, four products, product rounding, sum front, sum rounding.
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            d1_reg     <= in_data;
            ac_reg     <= fp_mul_front(d1_reg.fmap_real, d1_reg.filter_real);
            bd_reg     <= fp_mul_front(d1_reg.fmap_imag, d1_reg.filter_imag);
            bc_reg     <= fp_mul_front(d1_reg.fmap_imag, d1_reg.filter_real);
            ad_reg     <= fp_mul_front(d1_reg.fmap_real, d1_reg.filter_imag);
            ac_f_reg   <= fp_finish(ac_reg);
            bd_f_reg   <= fp_finish(bd_reg);
            bc_f_reg   <= fp_finish(bc_reg);
            ad_f_reg   <= fp_finish(ad_reg) ^ 32'h8000_0000;
            re_mid_reg <= fp_add_front(ac_f_reg, bd_f_reg);
            im_mid_reg <= fp_add_front(bc_f_reg, ad_f_reg);
            re_reg     <= fp_finish(re_mid_reg);
            im_reg     <= fp_finish(im_mid_reg);
        end
    end

    assign out_valid = vld_reg[4];
    assign out_ctrl  = ctl_reg[4];
    assign out_re    = re_reg;
    assign out_im    = im_reg;

endmodule

/* hw/rtl/ccmac_acc.sv */
// Accumulator store with read-modify-write, write bypass and the result register.
`timescale 1ns / 1ps
module ccmac_acc
    import ccmac_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  item_ctrl_t  in_ctrl,
    input  logic [31:0] in_re,
    input  logic [31:0] in_im,
    output logic        pipe_en,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    logic [63:0]  acc_mem [MAX_CHANNELS];
    logic [63:0]  rd_data_reg;
    logic         a1_valid_reg, a2_valid_reg;
    item_ctrl_t   a1_ctrl_reg, a2_ctrl_reg;
    logic [31:0]  a1_re_reg, a1_im_reg;
    fp_mid_t      a2_re_reg, a2_im_reg;
    logic [31:0]  prev_re, prev_im;
    logic [31:0]  acc_re, acc_im;
    logic         wr_en;
    logic         m_valid_reg;
    logic [71:0]  m_data_reg;
    logic         m_user_reg;
    logic         m_last_reg;

    assign pipe_en = !m_valid_reg || m_tready;

    // Finished sums of the oldest stage.
    assign acc_re = fp_finish(a2_re_reg);
    assign acc_im = fp_finish(a2_im_reg);
    assign wr_en  = pipe_en && a2_valid_reg;

    // Store write, and read with bypass of a write to the same entry in the same cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            acc_mem[a2_ctrl_reg.oc] <= {acc_im, acc_re};
        end
        if (pipe_en) begin
            if (wr_en && (a2_ctrl_reg.oc == in_ctrl.oc)) begin
                rd_data_reg <= {acc_im, acc_re};
            end else begin
                rd_data_reg <= acc_mem[in_ctrl.oc];
            end
        end
    end

    // The first input channel starts from +0.
    assign prev_re = a1_ctrl_reg.first ? 32'd0 : rd_data_reg[31:0];
    assign prev_im = a1_ctrl_reg.first ? 32'd0 : rd_data_reg[63:32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a1_valid_reg <= 1'b0;
            a2_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            a1_valid_reg <= in_valid;
            a2_valid_reg <= a1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            a1_ctrl_reg <= in_ctrl;
            a1_re_reg   <= in_re;
            a1_im_reg   <= in_im;
            a2_ctrl_reg <= a1_ctrl_reg;
            a2_re_reg   <= fp_add_front(prev_re, a1_re_reg);
            a2_im_reg   <= fp_add_front(prev_im, a1_im_reg);
        end
    end

    // Result register: loads on the last input channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= a2_valid_reg && a2_ctrl_reg.last_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_data_reg <= {1'b0, a2_ctrl_reg.oc, acc_im, acc_re};
            m_user_reg <= a2_ctrl_reg.last_out;
            m_last_reg <= a2_ctrl_reg.last_frame;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* hw/rtl/ccmac_checker.sv */
// Port-level checks for the complex MAC block and their binding to the top level.
`timescale 1ns / 1ps
module ccmac_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [71:0]  m_tdata,
    input logic [0:0]   m_tuser,
    input logic         m_tlast
);

    // No result is offered straight after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // The end of a frame is always the last output channel of a pixel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("frame end without pixel end");

    // A stalled result register stops new requests.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while output stalled");

endmodule

bind complex_conj_mac_channel_accumulate ccmac_checker u_ccmac_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* bench/tb_complex_conj_mac_channel_accumulate.sv */
// Self-checking bench for the complex conjugate multiply-accumulate block.
`timescale 1ns / 1ps

module tb_complex_conj_mac_channel_accumulate;
    import ccmac_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 30;
    localparam int ITEM_TARGET  = 1950;

    // One finished channel sum as the block should send it.
    typedef struct {
        bit [31:0] re;
        bit [31:0] im;
        bit [6:0]  channel;
        bit        pixel_end;
        bit        frame_end;
    } channel_sum_t;

    // Predicts the sums from the accepted requests and checks each result against them.
    class conj_mac_tracker;
        bit [8:0]     side_reg;
        bit [7:0]     cin_reg;
        bit [7:0]     cout_reg;
        bit [31:0]    acc_re [MAX_CHANNELS];
        bit [31:0]    acc_im [MAX_CHANNELS];
        int unsigned  in_cnt;
        int unsigned  out_cnt;
        int unsigned  col_cnt;
        int unsigned  row_cnt;
        channel_sum_t pending_sums[$];
        int           errors;
        int           requests;
        int           results;

        function new();
            side_reg = 9'd75;
            cin_reg  = 8'd32;
            cout_reg = 8'd32;
            in_cnt   = 0;
            out_cnt  = 0;
            col_cnt  = 0;
            row_cnt  = 0;
            errors   = 0;
            requests = 0;
            results  = 0;
            foreach (acc_re[i]) begin
                acc_re[i] = '0;
                acc_im[i] = '0;
            end
        endfunction

        function void write_reg(cfg_index_t idx, bit [8:0] val);
            case (idx)
                REG_FRAME_SIDE:   side_reg = val;
                REG_CHANNELS_IN:  cin_reg  = val[7:0];
                REG_CHANNELS_OUT: cout_reg = val[7:0];
                default: ;
            endcase
        endfunction

        // Zero acts as one; oversized values saturate.
        static function int unsigned clamp(int unsigned v, int unsigned hi);
            if (v == 0) begin
                return 1;
            end
            return (v > hi) ? hi : v;
        endfunction

        static function int top_one(bit [63:0] m);
            for (int i = 63; i > 0; i--) begin
                if (m[i]) begin
                    return i;
                end
            end
            return 0;
        endfunction

        // Round sign * m * 2^q to binary32, nearest even; lsb of m may be sticky.
        static function bit [31:0] pack_rounded(bit s, int q, bit [63:0] m);
            int        sh;
            int        e0;
            int        bexp;
            bit [63:0] k;
            bit [63:0] half;
            bit [63:0] rem;
            bit        up;
            if (m == 0) begin
                return {s, 31'd0};
            end
            sh = top_one(m) - 23;
            if (-149 - q > sh) begin
                sh = -149 - q;
            end
            if (sh <= 0) begin
                k = m << (-sh);
            end else begin
                up = 1'b0;
                if (sh < 64) begin
                    half = 64'd1 << (sh - 1);
                    k    = m >> sh;
                    rem  = m & ((64'd1 << sh) - 64'd1);
                    up   = (rem > half) || ((rem == half) && k[0]);
                end else begin
                    k = 0;
                    if (sh == 64) begin
                        up = m > (64'd1 << 63);
                    end
                end
                if (up) begin
                    k = k + 1;
                end
            end
            e0 = q + sh;
            if (k >= (64'd1 << 24)) begin
                k  = k >> 1;
                e0 = e0 + 1;
            end
            if (k >= (64'd1 << 23)) begin
                bexp = e0 + 150;
                if (bexp >= 255) begin
                    return {s, 8'hFF, 23'd0};
                end
                return {s, bexp[7:0], k[22:0]};
            end
            return {s, 8'd0, k[22:0]};
        endfunction

        static function bit nan_of(bit [31:0] x);
            return (x[30:23] == 8'hFF) && (x[22:0] != 0);
        endfunction

        static function bit inf_of(bit [31:0] x);
            return x[30:0] == 31'h7F80_0000;
        endfunction

        static function bit zero_of(bit [31:0] x);
            return x[30:0] == 0;
        endfunction

        static function bit [63:0] sig_of(bit [31:0] x);
            return (x[30:23] == 0) ? {41'd0, x[22:0]} : {40'd0, 1'b1, x[22:0]};
        endfunction

        static function int exp_of(bit [31:0] x);
            return (x[30:23] == 0) ? -149 : int'(x[30:23]) - 150;
        endfunction

        static function bit [31:0] mul32(bit [31:0] a, bit [31:0] b);
            bit s;
            s = a[31] ^ b[31];
            if (nan_of(a) || nan_of(b)) begin
                return QNAN;
            end
            if ((inf_of(a) && zero_of(b)) || (inf_of(b) && zero_of(a))) begin
                return QNAN;
            end
            if (inf_of(a) || inf_of(b)) begin
                return {s, 8'hFF, 23'd0};
            end
            return pack_rounded(s, exp_of(a) + exp_of(b), sig_of(a) * sig_of(b));
        endfunction

        static function bit [31:0] add32(bit [31:0] a, bit [31:0] b);
            bit [63:0] mx;
            bit [63:0] my;
            int        qx;
            int        qy;
            int        d;
            int        q;
            int        r;
            bit        sx;
            bit        sy;
            if (nan_of(a) || nan_of(b)) begin
                return QNAN;
            end
            if (inf_of(a) && inf_of(b)) begin
                return (a[31] == b[31]) ? a : QNAN;
            end
            if (inf_of(a)) begin
                return a;
            end
            if (inf_of(b)) begin
                return b;
            end
            if (exp_of(a) >= exp_of(b)) begin
                mx = sig_of(a); qx = exp_of(a); sx = a[31];
                my = sig_of(b); qy = exp_of(b); sy = b[31];
            end else begin
                mx = sig_of(b); qx = exp_of(b); sx = b[31];
                my = sig_of(a); qy = exp_of(a); sy = a[31];
            end
            d = qx - qy;
            if (d <= 39) begin
                mx = mx << d;
                q  = qy;
            end else begin
                // Far operand shrinks to a sticky tail below the near one.
                r  = d - 39;
                mx = mx << 39;
                q  = qx - 39;
                if (r < 64) begin
                    my = (my >> r) | 64'((my & ((64'd1 << r) - 64'd1)) != 0);
                end else begin
                    my = 64'(my != 0);
                end
            end
            if (sx == sy) begin
                return pack_rounded(sx, q, mx + my);
            end
            if (mx > my) begin
                return pack_rounded(sx, q, mx - my);
            end
            if (my > mx) begin
                return pack_rounded(sy, q, my - mx);
            end
            return 32'd0;
        endfunction

        // Accumulate one accepted request and queue its sum on the last input channel.
        function void note_request(bit [31:0] a, bit [31:0] b, bit [31:0] c, bit [31:0] d);
            int unsigned  ci;
            int unsigned  co;
            int unsigned  fs;
            int unsigned  oc;
            bit [31:0]    re;
            bit [31:0]    im;
            bit           l_in;
            bit           l_out;
            bit           l_col;
            bit           l_row;
            channel_sum_t sum;
            ci = clamp(cin_reg, MAX_CHANNELS);
            co = clamp(cout_reg, MAX_CHANNELS);
            fs = clamp(side_reg, MAX_SIDE);
            oc = (out_cnt >= MAX_CHANNELS) ? MAX_CHANNELS - 1 : out_cnt;
            requests++;
            re = add32(mul32(a, c), mul32(b, d));
            im = add32(mul32(b, c), mul32(a, d) ^ 32'h8000_0000);
            acc_re[oc] = add32((in_cnt == 0) ? 32'd0 : acc_re[oc], re);
            acc_im[oc] = add32((in_cnt == 0) ? 32'd0 : acc_im[oc], im);
            l_in  = in_cnt >= ci - 1;
            l_out = out_cnt >= co - 1;
            l_col = col_cnt >= fs - 1;
            l_row = row_cnt >= fs - 1;
            if (l_in) begin
                sum.re        = acc_re[oc];
                sum.im        = acc_im[oc];
                sum.channel   = oc[6:0];
                sum.pixel_end = l_out;
                sum.frame_end = l_out && l_col && l_row;
                pending_sums.push_back(sum);
            end
            // Counters advance output channel first, then input channel, column, row.
            if (!l_out) begin
                out_cnt++;
            end else begin
                out_cnt = 0;
                if (!l_in) begin
                    in_cnt++;
                end else begin
                    in_cnt = 0;
                    if (!l_col) begin
                        col_cnt++;
                    end else begin
                        col_cnt = 0;
                        row_cnt = l_row ? 0 : row_cnt + 1;
                    end
                end
            end
        endfunction

        function void check_result(bit [31:0] re, bit [31:0] im, bit [6:0] ch,
                                   bit pix, bit frm);
            channel_sum_t want;
            results++;
            if (pending_sums.size() == 0) begin
                $error("unexpected result: out_real %h out_imag %h out_channel %0d",
                       re, im, ch);
                errors++;
                return;
            end
            want = pending_sums.pop_front();
            if (re != want.re) begin
                $error("out_real: expected %h, got %h", want.re, re);
                errors++;
            end
            if (im != want.im) begin
                $error("out_imag: expected %h, got %h", want.im, im);
                errors++;
            end
            if (ch != want.channel) begin
                $error("out_channel: expected %0d, got %0d", want.channel, ch);
                errors++;
            end
            if (pix != want.pixel_end) begin
                $error("last_of_pixel: expected %0d, got %0d", want.pixel_end, pix);
                errors++;
            end
            if (frm != want.frame_end) begin
                $error("last_of_frame: expected %0d, got %0d", want.frame_end, frm);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [127:0]          s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [71:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;

    conj_mac_tracker tracker = new();
    bit              gaps_on = 1'b1;
    int              cycles = 0;
    int              phases = 0;

    complex_conj_mac_channel_accumulate dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever begin
            #5 aclk = ~aclk;
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (!gaps_on) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            return 0;
        end
        if (roll < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Operand values weighted towards ordinary numbers, with specials and raw bits.
    function automatic bit [31:0] pick_operand();
        bit [31:0] specials [10];
        int        roll;
        specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0000, 32'hFFBF_FFFF, 32'h0000_0001, 32'h7F7F_FFFF,
                     32'h3F80_0000, 32'h807F_FFFF};
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
        end
        if (roll < 75) begin
            return $urandom;
        end
        if (roll < 85) begin
            return {1'($urandom), 8'd0, 23'($urandom)};
        end
        return specials[$urandom_range(0, 9)];
    endfunction

    // Result side: random stalls and checking of each accepted result.
    initial begin
        int stall;
        m_tready = 1'b0;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                stall = pick_gap();
                m_tready <= (stall == 0);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_result(m_tdata[31:0], m_tdata[63:32], m_tdata[70:64],
                                 m_tuser[0], m_tlast);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_complex_conj_mac_channel_accumulate: errors");
            $finish;
        end
    end

    task automatic send_request(input bit [31:0] a, input bit [31:0] b,
                                input bit [31:0] c, input bit [31:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {d, c, b, a};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        tracker.note_request(a, b, c, d);
        @(negedge aclk);
    endtask

    // Wait for every expected sum, then let in-flight requests without a sum drain.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.pending_sums.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic configure(input bit [8:0] side, input bit [8:0] cin, input bit [8:0] cout);
        cfg_index_t idx [3];
        bit [8:0]   val [3];
        idx = '{REG_FRAME_SIDE, REG_CHANNELS_IN, REG_CHANNELS_OUT};
        val = '{side, cin, cout};
        settle();
        for (int i = 0; i < 3; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= val[i];
            tracker.write_reg(idx[i], val[i]);
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
        phases++;
    endtask

    // Whole pixels only, so a later register change never reads a stale entry.
    task automatic send_pixels(input int count);
        int per_pixel;
        per_pixel = conj_mac_tracker::clamp(tracker.cin_reg, MAX_CHANNELS) *
                    conj_mac_tracker::clamp(tracker.cout_reg, MAX_CHANNELS);
        repeat (count * per_pixel) begin
            send_request(pick_operand(), pick_operand(), pick_operand(), pick_operand());
        end
    endtask

    // Main sequence.
    initial begin
        bit [31:0] directed [16][4];
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed values: overflow, infinities, NaN, subnormals, cancellation.
        directed = '{
            '{32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000},
            '{32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF},
            '{32'h7F80_0000, 32'h0000_0000, 32'h0000_0000, 32'h3F80_0000},
            '{32'h7FC0_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000},
            '{32'h0000_0001, 32'h807F_FFFF, 32'h3F00_0000, 32'h3F80_0000},
            '{32'h7F80_0000, 32'h7F80_0000, 32'h3F80_0000, 32'hBF80_0000},
            '{32'h8000_0000, 32'h0000_0000, 32'h3F80_0000, 32'h0000_0000},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
            '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
            '{32'h0080_0000, 32'h0080_0000, 32'h3E80_0000, 32'h3E80_0000},
            '{32'h7F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h0000_0000},
            '{32'hFF80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000},
            '{32'h3F80_0001, 32'h3380_0000, 32'h3F80_0000, 32'h3F80_0000},
            '{32'h4B80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'hC000_0000},
            '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA},
            '{32'h0000_0000, 32'hFF7F_FFFF, 32'h3F80_0000, 32'h3F80_0000}
        };
        configure(9'd2, 9'd2, 9'd2);
        foreach (directed[i]) begin
            send_request(directed[i][0], directed[i][1], directed[i][2], directed[i][3]);
        end

        // Register extremes: zero, saturating channels and side, single output channel.
        configure(9'd0, 9'd0, 9'd0);
        send_pixels(6);
        configure(9'd511, 9'd1, 9'd255);
        send_pixels(3);
        configure(9'd3, 9'd255, 9'd1);
        send_pixels(2);
        configure(9'd1, 9'd1, 9'd1);
        send_pixels(20);

        // Random small settings; some phases run flat out with no gaps.
        while (tracker.requests < ITEM_TARGET) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            configure(9'($urandom_range(1, 4)), 9'($urandom_range(1, 6)),
                      9'($urandom_range(1, 6)));
            send_pixels($urandom_range(3, 12));
        end
        gaps_on = 1'b1;

        settle();
        $display("Covered %0d requests and %0d results over %0d register settings,",
                 tracker.requests, tracker.results, phases);
        $display("with special operands, saturated and zero registers, and random stalls.");
        if (tracker.errors == 0 && tracker.pending_sums.size() == 0) begin
            $display("tb_complex_conj_mac_channel_accumulate: clean");
        end else begin
            $display("tb_complex_conj_mac_channel_accumulate: errors");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/ccmac_pkg.sv
hw/rtl/ccmac_ctrl.sv
hw/rtl/ccmac_cmul.sv
hw/rtl/ccmac_acc.sv
hw/rtl/complex_conj_mac_channel_accumulate.sv
hw/rtl/ccmac_checker.sv
bench/tb_complex_conj_mac_channel_accumulate.sv
